>>> rtl/sop_pkg.sv
// Shared types, sizes and state codes for the sphere overlap push block.
// Used by sphere_overlap_push; depends on nothing else.
`default_nettype none
package sop_pkg;

    localparam int MAX_OBJECTS   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_W         = $clog2(MAX_OBJECTS);
    localparam int CNT_W         = $clog2(MAX_OBJECTS + 1);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [30:0] radius;
        logic               last_object;
    } t_in;

    typedef struct packed {
        logic        [5:0]  object_index;
        logic signed [39:0] push_x;
        logic signed [39:0] push_y;
        logic signed [39:0] push_z;
        logic               last_result;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [30:0] r;
    } t_sphere;

    typedef struct packed {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [39:0] z;
    } t_push;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RD_I,
        ST_RD_J,
        ST_DIFF,
        ST_CHK,
        ST_MUL,
        ST_SQRT,
        ST_DCHK,
        ST_DMUL,
        ST_DSTART,
        ST_DWAIT,
        ST_UPD_I,
        ST_WR_I,
        ST_WR_J,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

>>> rtl/sop_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Divides a 64-bit value by a 32-bit value whose quotient fits in 32 bits.
`default_nettype none
module sop_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic      [31:0] o_quot
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_den;
    logic [32:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_low[31]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign o_quot  = r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // The upper half of the dividend is below the divisor, so it is the
    // starting remainder and only 32 quotient bits remain to be found.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_low <= i_dividend[31:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
            r_low <= {r_low[30:0], w_ge};
        end
    end
endmodule
`default_nettype wire

>>> rtl/sphere_overlap_push.sv
// Top level: sphere store, pair sequencer, overlap math and push output.
// Depends on sop_pkg and sop_div.
//
//  channel   | valid    | stall    | payload
//  input     | i_valid  | o_stall  | i_item   (t_in)
//  output    | o_valid  | i_stall  | o_result (t_out)
//
// Loading accepts one sphere per cycle. After the last sphere each pair is
// checked axis by axis, then on its full distance through one shared
// multiplier; an overlapping pair then runs through a 32-step square root
// and three 32-step divisions. Each result is read from the push store and
// held on the output until it is taken, and only then is the next one read.
// Reset is synchronous and clears the sequencer and the object count; the
// stores need no clearing pass.
`default_nettype none
module sphere_overlap_push (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire sop_pkg::t_in  i_item,
    output logic               o_valid,
    input  wire logic          i_stall,
    output sop_pkg::t_out      o_result
);
    import sop_pkg::*;

    t_state r_state, n_state;

    t_sphere r_pos_mem [MAX_OBJECTS];
    t_push   r_push_mem [MAX_OBJECTS];
    t_sphere r_pos_q, r_pi;
    t_push   r_push_q;

    logic             pos_we, pos_re, push_we, push_re;
    logic [IDX_W-1:0] pos_waddr, pos_raddr, push_waddr, push_raddr;
    t_sphere          pos_wdata;
    t_push            push_wdata;

    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic [5:0]       r_cyc;
    logic [1:0]       r_c;

    logic signed [32:0] r_dx, r_dy, r_dz;
    logic        [31:0] r_rs;
    logic        [63:0] r_prod;
    logic        [65:0] r_sum;
    logic        [63:0] r_rad;
    logic        [33:0] r_rem;
    logic        [31:0] r_root;
    logic        [31:0] r_ovl;
    logic signed [32:0] r_pv [3];

    logic [32:0] ax, ay, az, ac;
    logic        sc;
    logic [31:0] mul_a, mul_b;
    logic [35:0] sq_tr;
    logic [33:0] sq_trial;
    logic        accept_in, accept_out, in_full, last_k;
    logic [CNT_W-1:0] cnt_after, j_next, i_next2;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic signed [32:0] w_dx, w_dy, w_dz;

    function automatic logic signed [39:0] sat_add(input logic signed [39:0] a,
                                                   input logic signed [32:0] b);
        logic signed [40:0] s;
        s = 41'(a) + 41'(b);
        if (s > 41'sd549755813887) begin
            return 40'sh7FFFFFFFFF;
        end else if (s < -41'sd549755813888) begin
            return 40'sh8000000000;
        end
        return s[39:0];
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    sop_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_root),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign accept_in  = i_valid && !o_stall;
    assign accept_out = o_valid && !i_stall;
    assign in_full    = r_cnt == CNT_W'(MAX_OBJECTS);
    assign cnt_after  = in_full ? r_cnt : r_cnt + CNT_W'(1);
    assign j_next     = CNT_W'(r_j) + CNT_W'(1);
    assign i_next2    = CNT_W'(r_i) + CNT_W'(2);
    assign last_k     = CNT_W'(r_k) + CNT_W'(1) == r_cnt;

    assign w_dx = 33'(r_pi.x) - 33'(r_pos_q.x);
    assign w_dy = 33'(r_pi.y) - 33'(r_pos_q.y);
    assign w_dz = 33'(r_pi.z) - 33'(r_pos_q.z);

    assign ax = mag33(r_dx);
    assign ay = mag33(r_dy);
    assign az = mag33(r_dz);

    always_comb begin
        case (r_c)
            2'd0:    begin ac = ax; sc = r_dx[32]; end
            2'd1:    begin ac = ay; sc = r_dy[32]; end
            default: begin ac = az; sc = r_dz[32]; end
        endcase
    end

    always_comb begin
        mul_a = ac[31:0];
        mul_b = r_ovl;
        if (r_state == ST_MUL) begin
            case (r_cyc[2:0])
                3'd0:    begin mul_a = ax[31:0]; mul_b = ax[31:0]; end
                3'd1:    begin mul_a = ay[31:0]; mul_b = ay[31:0]; end
                3'd2:    begin mul_a = az[31:0]; mul_b = az[31:0]; end
                default: begin mul_a = r_rs;     mul_b = r_rs;     end
            endcase
        end
    end

    assign sq_tr    = {r_rem, r_rad[63:62]};
    assign sq_trial = {r_root, 2'b01};

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re) begin
            r_pos_q <= r_pos_mem[pos_raddr];
        end
        if (push_we) begin
            r_push_mem[push_waddr] <= push_wdata;
        end
        if (push_re) begin
            r_push_q <= r_push_mem[push_raddr];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (accept_in && i_item.last_object) begin
                    n_state = (cnt_after < CNT_W'(2)) ? ST_OUT_RD : ST_RD_I;
                end
            end
            ST_RD_I:   n_state = ST_RD_J;
            ST_RD_J:   n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_CHK;
            ST_CHK: begin
                if (ax >= {1'b0, r_rs} || ay >= {1'b0, r_rs} || az >= {1'b0, r_rs}) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_cyc[2:0] == 3'd4) begin
                    n_state = (r_sum < {2'b00, r_prod}) ? ST_SQRT : ST_NEXT;
                end
            end
            ST_SQRT:   n_state = (r_cyc == 6'd31) ? ST_DCHK : ST_SQRT;
            ST_DCHK:   n_state = (r_root == '0) ? ST_NEXT : ST_DMUL;
            ST_DMUL:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (div_done) begin
                    n_state = (r_c == 2'd2) ? ST_UPD_I : ST_DMUL;
                end
            end
            ST_UPD_I:  n_state = ST_WR_I;
            ST_WR_I:   n_state = ST_WR_J;
            ST_WR_J:   n_state = ST_NEXT;
            ST_NEXT: begin
                if (j_next < r_cnt || i_next2 < r_cnt) begin
                    n_state = ST_RD_I;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: n_state = ST_OUT;
            ST_OUT: begin
                if (accept_out) begin
                    n_state = last_k ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:   n_state = ST_LOAD;
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        o_stall    = r_state != ST_LOAD;
        o_valid    = r_state == ST_OUT;
        pos_we     = 1'b0;
        pos_re     = 1'b0;
        push_we    = 1'b0;
        push_re    = 1'b0;
        pos_waddr  = r_cnt[IDX_W-1:0];
        pos_raddr  = r_i;
        push_waddr = r_cnt[IDX_W-1:0];
        push_raddr = r_i;
        pos_wdata  = '{x: i_item.pos_x, y: i_item.pos_y, z: i_item.pos_z,
                       r: i_item.radius};
        push_wdata = '0;
        div_start  = 1'b0;
        case (r_state)
            ST_LOAD: begin
                // A sphere's push sum is zeroed as the sphere is loaded.
                pos_we  = accept_in && !in_full;
                push_we = accept_in && !in_full;
            end
            ST_RD_I:   pos_re = 1'b1;
            ST_RD_J: begin
                pos_re    = 1'b1;
                pos_raddr = r_j;
            end
            ST_DSTART: div_start = 1'b1;
            ST_UPD_I:  push_re = 1'b1;
            ST_WR_I: begin
                push_we    = 1'b1;
                push_waddr = r_i;
                push_wdata = '{x: sat_add(r_push_q.x, r_pv[0]),
                               y: sat_add(r_push_q.y, r_pv[1]),
                               z: sat_add(r_push_q.z, r_pv[2])};
                push_re    = 1'b1;
                push_raddr = r_j;
            end
            ST_WR_J: begin
                push_we    = 1'b1;
                push_waddr = r_j;
                push_wdata = '{x: sat_add(r_push_q.x, 33'(-r_pv[0])),
                               y: sat_add(r_push_q.y, 33'(-r_pv[1])),
                               z: sat_add(r_push_q.z, 33'(-r_pv[2]))};
            end
            ST_OUT_RD: begin
                push_re    = 1'b1;
                push_raddr = r_k;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.object_index = 6'(r_k);
        o_result.push_x       = r_push_q.x;
        o_result.push_y       = r_push_q.y;
        o_result.push_z       = r_push_q.z;
        o_result.last_result  = last_k;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_cyc   <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    if (accept_in) begin
                        r_cnt <= cnt_after;
                        r_i   <= '0;
                        r_j   <= IDX_W'(1);
                        r_k   <= '0;
                    end
                end
                ST_CHK:   r_cyc <= '0;
                ST_MUL: begin
                    r_cyc <= (r_cyc[2:0] == 3'd4) ? 6'd0 : r_cyc + 6'd1;
                end
                ST_SQRT:  r_cyc <= r_cyc + 6'd1;
                ST_DCHK:  r_c <= '0;
                ST_DWAIT: begin
                    if (div_done) begin
                        r_c <= r_c + 2'd1;
                    end
                end
                ST_NEXT: begin
                    if (j_next < r_cnt) begin
                        r_j <= r_j + IDX_W'(1);
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                        r_j <= i_next2[IDX_W-1:0];
                    end
                end
                ST_OUT: begin
                    if (accept_out) begin
                        r_k <= r_k + IDX_W'(1);
                        if (last_k) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            ST_RD_J: r_pi <= r_pos_q;
            ST_DIFF: begin
                r_dx <= w_dx;
                r_dy <= w_dy;
                r_dz <= w_dz;
                r_rs <= 32'(r_pi.r) + 32'(r_pos_q.r);
            end
            ST_MUL: begin
                case (r_cyc[2:0])
                    3'd1:    r_sum <= {2'b00, r_prod};
                    3'd2,
                    3'd3:    r_sum <= r_sum + {2'b00, r_prod};
                    default: ;
                endcase
                r_rad  <= r_sum[63:0];
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_SQRT: begin
                // One result bit per cycle, two radicand bits consumed.
                r_rad <= {r_rad[61:0], 2'b00};
                if (sq_tr >= {2'b00, sq_trial}) begin
                    r_rem  <= 34'(sq_tr - {2'b00, sq_trial});
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= sq_tr[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            ST_DCHK: r_ovl <= r_rs - r_root;
            ST_DWAIT: begin
                if (div_done) begin
                    r_pv[r_c] <= sc ? 33'(-{1'b0, div_q}) : 33'({1'b0, div_q});
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
